>>> hw/rtl/trvp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace ring package
// Command, record and status codes, controller states and the
// controller/datapath handshake types shared by the trace ring modules.
// ----------------------------------------------------------------------------
package trvp_pkg;

	// Width of a move count as it travels through the ports and count store
	localparam int CNT_W  = 5;
	// Width of the wished tick count
	localparam int WISH_W = 16;

	typedef enum logic [1:0] {
		CMD_BEGIN   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_READOUT = 2'd2,
		CMD_NEXT    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_ACK  = 2'd0,
		KIND_TICK = 2'd1,
		KIND_MOVE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_MOVE_OVER = 2'd1,
		STAT_NO_READ   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_BEGIN_B,
		S_MOVE_RD,
		S_TICK_RD
	} state_t;

	// Operation the controller asks of the datapath in the current cycle
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LATCH,
		OP_BEGIN_A,
		OP_BEGIN_B,
		OP_APPEND,
		OP_SKIP_MOVE,
		OP_READOUT,
		OP_NO_READ,
		OP_MOVE_ISSUE,
		OP_MOVE_RESP,
		OP_TICK_ISSUE,
		OP_TICK_RESP
	} op_t;

	// Datapath status seen by the controller
	typedef struct packed {
		cmd_t cmd;
		logic pending_zero;
		logic moves_left_zero;
		logic ticks_left_zero;
	} dp_stat_t;

endpackage

>>> hw/rtl/trvp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module trvp_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write on request, register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/trvp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace ring controller
// Accepts one command, sequences its datapath operations through S_DECODE
// and, where needed, S_BEGIN_B, S_MOVE_RD or S_TICK_RD, and returns to idle.
// ----------------------------------------------------------------------------
module trvp_ctrl import trvp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output op_t      op,
	output logic     busy
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_BEGIN: state_d = S_BEGIN_B;
					CMD_NEXT: begin
						if (!stat.moves_left_zero) begin
							state_d = S_MOVE_RD;
						end else if (!stat.ticks_left_zero) begin
							state_d = S_TICK_RD;
						end else begin
							state_d = S_IDLE;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		op   = OP_NONE;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (start) begin
					op = OP_LATCH;
				end
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_BEGIN:   op = OP_BEGIN_A;
					CMD_APPEND:  op = stat.pending_zero ? OP_SKIP_MOVE : OP_APPEND;
					CMD_READOUT: op = OP_READOUT;
					CMD_NEXT: begin
						if (!stat.moves_left_zero) begin
							op = OP_MOVE_ISSUE;
						end else if (!stat.ticks_left_zero) begin
							op = OP_TICK_ISSUE;
						end else begin
							op = OP_NO_READ;
						end
					end
					default: op = OP_NONE;
				endcase
			end
			S_BEGIN_B: op = OP_BEGIN_B;
			S_MOVE_RD: op = OP_MOVE_RESP;
			S_TICK_RD: op = OP_TICK_RESP;
			default:   op = OP_NONE;
		endcase
	end

	a_decode_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DECODE |-> $past(state_q == S_IDLE && start))
		else $error("decode entered without an accepted command");

	a_move_read_has_moves: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MOVE_RD |-> $past(!stat.moves_left_zero && stat.cmd == CMD_NEXT))
		else $error("move read started with no moves left");

	a_tick_read_has_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TICK_RD |-> $past(!stat.ticks_left_zero && stat.moves_left_zero))
		else $error("tick read started with no ticks left or moves pending");

endmodule

>>> hw/rtl/trvp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace ring datapath
// Tick, count and move stores, write and readout pointers, and the result
// register. Carries out the operation named by the controller each cycle.
// ----------------------------------------------------------------------------
module trvp_dp import trvp_pkg::*; #(
	parameter int TICK_DEPTH         = 1024,
	parameter int MAX_MOVES_PER_TICK = 16,
	parameter int MOVE_DEPTH         = 16384,
	parameter int TICK_BITS          = 64,
	parameter int MOVE_BITS          = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  op_t                               op,
	output dp_stat_t                          stat,
	input  logic [1:0]                        command,
	input  logic [TICK_BITS-1:0]              tick_word,
	input  logic [CNT_W-1:0]                  move_count,
	input  logic [MOVE_BITS-1:0]              move_word,
	input  logic [WISH_W-1:0]                 wish_ticks,
	output logic                              done,
	output logic [1:0]                        kind,
	output logic [TICK_BITS-1:0]              out_tick,
	output logic [CNT_W-1:0]                  out_count,
	output logic [MOVE_BITS-1:0]              out_move,
	output logic [$clog2(TICK_DEPTH+1)-1:0]   ticks_found,
	output logic                              last,
	output logic [1:0]                        status
);

	localparam int TA_W = $clog2(TICK_DEPTH);
	localparam int TC_W = $clog2(TICK_DEPTH + 1);
	localparam int MA_W = $clog2(MOVE_DEPTH);
	localparam int TR_W = TICK_BITS + MA_W;

	// Latched command beat
	logic [1:0]           cmd_q;
	logic [TICK_BITS-1:0] tick_word_q;
	logic [CNT_W-1:0]     move_count_q;
	logic [MOVE_BITS-1:0] move_word_q;
	logic [WISH_W-1:0]    wish_q;

	// Write side
	logic [TA_W-1:0]  tick_wr_ptr_q;
	logic             wrapped_q;
	logic [MA_W-1:0]  move_wr_ptr_q;
	logic [CNT_W-1:0] pending_q;
	logic [CNT_W-1:0] cur_cnt_q;

	// Readout side
	logic [TA_W-1:0]  rd_tick_ptr_q;
	logic [MA_W-1:0]  rd_move_ptr_q;
	logic [TC_W-1:0]  rd_ticks_left_q;
	logic [CNT_W-1:0] rd_moves_left_q;
	logic             tick_vld_s1;

	// Result register
	logic                 done_q;
	kind_t                kind_q;
	logic [TICK_BITS-1:0] out_tick_q;
	logic [CNT_W-1:0]     out_count_q;
	logic [MOVE_BITS-1:0] out_move_q;
	logic [TC_W-1:0]      found_q;
	logic                 last_q;
	status_t              status_q;

	// Memory ports
	logic             t_we;
	logic [TA_W-1:0]  t_addr;
	logic [TR_W-1:0]  t_wdata;
	logic [TR_W-1:0]  t_rdata;
	logic             c_we;
	logic [TA_W-1:0]  c_addr;
	logic [CNT_W-1:0] c_wdata;
	logic [CNT_W-1:0] c_rdata;
	logic             m_we;
	logic [MA_W-1:0]  m_addr;
	logic [MOVE_BITS-1:0] m_wdata;
	logic [MOVE_BITS-1:0] m_rdata;

	// Derived values
	logic [TA_W-1:0]      tick_next;
	logic [TA_W-1:0]      tick_prev;
	logic [TA_W-1:0]      rd_tick_next;
	logic [MA_W-1:0]      move_wr_next;
	logic [MA_W-1:0]      rd_move_next;
	logic [CNT_W-1:0]     sat_cnt;
	logic [TC_W-1:0]      n_found;
	logic [31:0]          rs_sum;
	logic [TA_W-1:0]      rs_ptr;
	logic [TICK_BITS-1:0] rd_hdr;
	logic [CNT_W-1:0]     rd_cnt;
	logic [MA_W-1:0]      rd_start;

	// Response staging
	logic                 resp_vld;
	kind_t                resp_kind;
	logic [TICK_BITS-1:0] resp_tick;
	logic [CNT_W-1:0]     resp_cnt;
	logic [MOVE_BITS-1:0] resp_move;
	logic [TC_W-1:0]      resp_found;
	logic                 resp_last;
	status_t              resp_stat;

	// Header and start pointer of each tick slot
	trvp_ram #(.WIDTH(TR_W), .DEPTH(TICK_DEPTH)) u_tick_ram (
		.clk   (clk),
		.we    (t_we),
		.addr  (t_addr),
		.wdata (t_wdata),
		.rdata (t_rdata)
	);

	// Move count of each tick slot
	trvp_ram #(.WIDTH(CNT_W), .DEPTH(TICK_DEPTH)) u_count_ram (
		.clk   (clk),
		.we    (c_we),
		.addr  (c_addr),
		.wdata (c_wdata),
		.rdata (c_rdata)
	);

	// Payload ring
	trvp_ram #(.WIDTH(MOVE_BITS), .DEPTH(MOVE_DEPTH)) u_move_ram (
		.clk   (clk),
		.we    (m_we),
		.addr  (m_addr),
		.wdata (m_wdata),
		.rdata (m_rdata)
	);

	// Ring arithmetic and saturation
	always_comb begin
		tick_next    = (tick_wr_ptr_q == TA_W'(TICK_DEPTH - 1)) ? '0 : tick_wr_ptr_q + 1'b1;
		tick_prev    = (tick_wr_ptr_q == '0) ? TA_W'(TICK_DEPTH - 1) : tick_wr_ptr_q - 1'b1;
		rd_tick_next = (rd_tick_ptr_q == TA_W'(TICK_DEPTH - 1)) ? '0 : rd_tick_ptr_q + 1'b1;
		move_wr_next = (move_wr_ptr_q == MA_W'(MOVE_DEPTH - 1)) ? '0 : move_wr_ptr_q + 1'b1;
		rd_move_next = (rd_move_ptr_q == MA_W'(MOVE_DEPTH - 1)) ? '0 : rd_move_ptr_q + 1'b1;
		sat_cnt      = (32'(move_count_q) > 32'(MAX_MOVES_PER_TICK))
		               ? CNT_W'(MAX_MOVES_PER_TICK) : move_count_q;
		n_found      = (32'(wish_q) < 32'(TICK_DEPTH)) ? TC_W'(wish_q) : TC_W'(TICK_DEPTH);
		rs_sum       = 32'(tick_wr_ptr_q) + 32'(TICK_DEPTH) - 32'(n_found);
		rs_ptr       = (rs_sum >= 32'(TICK_DEPTH)) ? TA_W'(rs_sum - 32'(TICK_DEPTH))
		                                           : TA_W'(rs_sum);
		// Slots never written since reset read back as empty ticks
		rd_hdr       = tick_vld_s1 ? t_rdata[MA_W +: TICK_BITS] : '0;
		rd_start     = tick_vld_s1 ? t_rdata[MA_W-1:0] : '0;
		rd_cnt       = tick_vld_s1 ? c_rdata : '0;
	end

	// Memory addressing
	always_comb begin
		t_we    = (op == OP_BEGIN_A);
		t_addr  = (op == OP_BEGIN_A) ? tick_wr_ptr_q : rd_tick_ptr_q;
		t_wdata = {tick_word_q, move_wr_ptr_q};

		// Trim an incomplete previous tick down to the moves it received
		c_we    = (op == OP_BEGIN_A && pending_q != '0) || (op == OP_BEGIN_B);
		c_wdata = (op == OP_BEGIN_B) ? sat_cnt : cur_cnt_q - pending_q;
		case (op)
			OP_BEGIN_A: c_addr = tick_prev;
			OP_BEGIN_B: c_addr = tick_wr_ptr_q;
			default:    c_addr = rd_tick_ptr_q;
		endcase

		m_we    = (op == OP_APPEND);
		m_addr  = (op == OP_APPEND) ? move_wr_ptr_q : rd_move_ptr_q;
		m_wdata = move_word_q;
	end

	// Hold the accepted command beat
	always_ff @(posedge clk) begin
		if (op == OP_LATCH) begin
			cmd_q        <= command;
			tick_word_q  <= tick_word;
			move_count_q <= move_count;
			move_word_q  <= move_word;
			wish_q       <= wish_ticks;
		end
	end

	// Advance write and readout pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_wr_ptr_q   <= '0;
			wrapped_q       <= 1'b0;
			move_wr_ptr_q   <= '0;
			pending_q       <= '0;
			cur_cnt_q       <= '0;
			rd_tick_ptr_q   <= '0;
			rd_move_ptr_q   <= '0;
			rd_ticks_left_q <= '0;
			rd_moves_left_q <= '0;
			tick_vld_s1     <= 1'b0;
		end else begin
			case (op)
				OP_BEGIN_B: begin
					tick_wr_ptr_q <= tick_next;
					if (tick_wr_ptr_q == TA_W'(TICK_DEPTH - 1)) begin
						wrapped_q <= 1'b1;
					end
					pending_q <= sat_cnt;
					cur_cnt_q <= sat_cnt;
				end
				OP_APPEND: begin
					move_wr_ptr_q <= move_wr_next;
					pending_q     <= pending_q - 1'b1;
				end
				OP_READOUT: begin
					rd_tick_ptr_q   <= rs_ptr;
					rd_ticks_left_q <= n_found;
					rd_moves_left_q <= '0;
					rd_move_ptr_q   <= '0;
				end
				OP_TICK_ISSUE: begin
					tick_vld_s1 <= wrapped_q || (rd_tick_ptr_q < tick_wr_ptr_q);
				end
				OP_TICK_RESP: begin
					rd_move_ptr_q   <= rd_start;
					rd_moves_left_q <= rd_cnt;
					rd_tick_ptr_q   <= rd_tick_next;
					rd_ticks_left_q <= rd_ticks_left_q - 1'b1;
				end
				OP_MOVE_RESP: begin
					rd_move_ptr_q   <= rd_move_next;
					rd_moves_left_q <= rd_moves_left_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Build the result beat
	always_comb begin
		resp_vld   = 1'b0;
		resp_kind  = KIND_ACK;
		resp_tick  = '0;
		resp_cnt   = '0;
		resp_move  = '0;
		resp_found = '0;
		resp_last  = 1'b0;
		resp_stat  = STAT_OK;
		case (op)
			OP_BEGIN_B, OP_APPEND: resp_vld = 1'b1;
			OP_SKIP_MOVE: begin
				resp_vld  = 1'b1;
				resp_stat = STAT_MOVE_OVER;
			end
			OP_READOUT: begin
				resp_vld   = 1'b1;
				resp_found = n_found;
				resp_last  = (n_found == '0);
			end
			OP_NO_READ: begin
				resp_vld  = 1'b1;
				resp_stat = STAT_NO_READ;
				resp_last = 1'b1;
			end
			OP_TICK_RESP: begin
				resp_vld  = 1'b1;
				resp_kind = KIND_TICK;
				resp_tick = rd_hdr;
				resp_cnt  = rd_cnt;
				resp_last = (rd_cnt == '0) && (rd_ticks_left_q == TC_W'(1));
			end
			OP_MOVE_RESP: begin
				resp_vld  = 1'b1;
				resp_kind = KIND_MOVE;
				resp_move = m_rdata;
				resp_last = (rd_moves_left_q == CNT_W'(1)) && (rd_ticks_left_q == '0);
			end
			default: begin
			end
		endcase
	end

	// Strobe the result for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= resp_vld;
		end
	end

	// Hold the result payload
	always_ff @(posedge clk) begin
		if (resp_vld) begin
			kind_q      <= resp_kind;
			out_tick_q  <= resp_tick;
			out_count_q <= resp_cnt;
			out_move_q  <= resp_move;
			found_q     <= resp_found;
			last_q      <= resp_last;
			status_q    <= resp_stat;
		end
	end

	assign done        = done_q;
	assign kind        = kind_q;
	assign out_tick    = out_tick_q;
	assign out_count   = out_count_q;
	assign out_move    = out_move_q;
	assign ticks_found = found_q;
	assign last        = last_q;
	assign status      = status_q;

	assign stat.cmd             = cmd_t'(cmd_q);
	assign stat.pending_zero    = (pending_q == '0);
	assign stat.moves_left_zero = (rd_moves_left_q == '0);
	assign stat.ticks_left_zero = (rd_ticks_left_q == '0);

	a_pending_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(pending_q) <= 32'(MAX_MOVES_PER_TICK) && pending_q <= cur_cnt_q)
		else $error("pending moves exceed the tick's count");

	a_ticks_left_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(rd_ticks_left_q) <= 32'(TICK_DEPTH))
		else $error("readout tick count exceeds ring depth");

	a_ptrs_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(tick_wr_ptr_q) < 32'(TICK_DEPTH) && 32'(rd_tick_ptr_q) < 32'(TICK_DEPTH)
		&& 32'(move_wr_ptr_q) < 32'(MOVE_DEPTH))
		else $error("ring pointer out of range");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for two cycles");

endmodule

>>> hw/rtl/trace_ring_with_variable_payload.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace ring with variable payload
// Keeps the newest TICK_DEPTH tick headers, each owning up to
// MAX_MOVES_PER_TICK payload words in a second ring, and reads them back.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken at a rising edge with start high and busy low:
//   begin tick, append move, start readout or next readout record.
//   Every command gives exactly one result beat, shown for a single cycle
//   with done high; the receiver cannot stall, so it must take the beat then.
// Sequencing:
//   Append, start readout and an idle next command build their result beat
//   in the decode state that follows the accepting edge; done is registered.
//   Begin tick and a next command that returns a header or move also pass
//   through S_BEGIN_B, S_TICK_RD or S_MOVE_RD, which holds the second
//   count-store write or the registered memory read. busy stays high from the
//   accepting edge until idle again, so no command is taken while one runs.
// Reset:
//   arst_n clears all pointers and counters. Tick slots not yet written read
//   back as empty ticks by comparison with the fill pointer, so no clearing
//   pass is needed and commands are taken as soon as reset is released.
// ----------------------------------------------------------------------------
module trace_ring_with_variable_payload import trvp_pkg::*; #(
	parameter int TICK_DEPTH         = 1024,
	parameter int MAX_MOVES_PER_TICK = 16,
	parameter int MOVE_DEPTH         = 16384,
	parameter int TICK_BITS          = 64,
	parameter int MOVE_BITS          = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      command,
	input  logic [TICK_BITS-1:0]            tick_word,
	input  logic [CNT_W-1:0]                move_count,
	input  logic [MOVE_BITS-1:0]            move_word,
	input  logic [WISH_W-1:0]               wish_ticks,
	output logic                            done,
	output logic [1:0]                      kind,
	output logic [TICK_BITS-1:0]            out_tick,
	output logic [CNT_W-1:0]                out_count,
	output logic [MOVE_BITS-1:0]            out_move,
	output logic [$clog2(TICK_DEPTH+1)-1:0] ticks_found,
	output logic                            last,
	output logic [1:0]                      status
);

	op_t      op;
	dp_stat_t stat;

	// Command sequencer
	trvp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.op     (op),
		.busy   (busy)
	);

	// Stores, pointers and result register
	trvp_dp #(
		.TICK_DEPTH         (TICK_DEPTH),
		.MAX_MOVES_PER_TICK (MAX_MOVES_PER_TICK),
		.MOVE_DEPTH         (MOVE_DEPTH),
		.TICK_BITS          (TICK_BITS),
		.MOVE_BITS          (MOVE_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.stat        (stat),
		.command     (command),
		.tick_word   (tick_word),
		.move_count  (move_count),
		.move_word   (move_word),
		.wish_ticks  (wish_ticks),
		.done        (done),
		.kind        (kind),
		.out_tick    (out_tick),
		.out_count   (out_count),
		.out_move    (out_move),
		.ticks_found (ticks_found),
		.last        (last),
		.status      (status)
	);

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trace ring testbench
// Drives begin-tick, append, readout and next commands into the trace ring.
// A local model of the tick and payload rings predicts every result beat;
// results are checked field by field in order of issue.
// ----------------------------------------------------------------------------
module testbench import trvp_pkg::*; ();

	localparam int TICKS     = 1024;
	localparam int MOVES_MAX = 16;
	localparam int RING      = 16384;
	localparam int WATCHDOG  = 1000;
	localparam int REPORTS   = 10;

	typedef struct {
		cmd_t        cmd;
		logic [63:0] tick_word;
		logic [4:0]  move_count;
		logic [63:0] move_word;
		logic [15:0] wish;
	} cmd_beat_t;

	typedef struct {
		kind_t       kind;
		logic [63:0] tick;
		logic [4:0]  count;
		logic [63:0] move;
		logic [10:0] found;
		logic        last;
		status_t     status;
	} record_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  command;
	logic [63:0] tick_word;
	logic [4:0]  move_count;
	logic [63:0] move_word;
	logic [15:0] wish_ticks;
	logic        done;
	logic [1:0]  kind;
	logic [63:0] out_tick;
	logic [4:0]  out_count;
	logic [63:0] out_move;
	logic [$clog2(TICKS+1)-1:0] ticks_found;
	logic        last;
	logic [1:0]  status;

	// Model of the trace rings
	logic [63:0] slot_header [TICKS];
	int unsigned slot_count [TICKS];
	int unsigned slot_base [TICKS];
	logic [63:0] word_store [RING];
	bit          word_written [RING];
	int unsigned next_slot, next_word, pending_moves;
	int unsigned read_slot, read_word, ticks_to_read, moves_to_read;

	record_t awaited_records[$];
	record_t head_record;
	int      mismatches;
	int      beats_sent;
	int      gap_pct;
	int      idle_cycles;

	trace_ring_with_variable_payload #(
		.TICK_DEPTH(TICKS),
		.MAX_MOVES_PER_TICK(MOVES_MAX),
		.MOVE_DEPTH(RING),
		.TICK_BITS(64),
		.MOVE_BITS(64)
	) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .tick_word(tick_word), .move_count(move_count),
		.move_word(move_word), .wish_ticks(wish_ticks), .done(done),
		.kind(kind), .out_tick(out_tick), .out_count(out_count),
		.out_move(out_move), .ticks_found(ticks_found), .last(last),
		.status(status)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Advance the model by one command and return the record it answers with
	function automatic record_t predict_record(cmd_beat_t b);
		record_t     r;
		int unsigned cnt, prev, n;
		r = '{kind: KIND_ACK, tick: '0, count: '0, move: '0, found: '0,
		      last: 1'b0, status: STAT_OK};
		case (b.cmd)
			CMD_BEGIN: begin
				cnt = (b.move_count > MOVES_MAX) ? MOVES_MAX : b.move_count;
				// trim an unfinished previous tick to the moves it really got
				if (pending_moves != 0) begin
					prev = (next_slot + TICKS - 1) % TICKS;
					slot_count[prev] = (slot_count[prev] >= pending_moves) ?
						slot_count[prev] - pending_moves : 0;
				end
				slot_header[next_slot] = b.tick_word;
				slot_count[next_slot]  = cnt;
				slot_base[next_slot]   = next_word;
				next_slot     = (next_slot + 1) % TICKS;
				pending_moves = cnt;
			end
			CMD_APPEND: begin
				if (pending_moves == 0) begin
					r.status = STAT_MOVE_OVER;
				end else begin
					word_store[next_word]   = b.move_word;
					word_written[next_word] = 1'b1;
					next_word = (next_word + 1) % RING;
					pending_moves--;
				end
			end
			CMD_READOUT: begin
				n = (b.wish < TICKS) ? b.wish : TICKS;
				read_slot     = (next_slot + TICKS - n) % TICKS;
				ticks_to_read = n;
				moves_to_read = 0;
				read_word     = 0;
				r.found       = 11'(n);
				r.last        = (n == 0);
			end
			default: begin
				if (moves_to_read != 0) begin
					r.kind    = KIND_MOVE;
					r.move    = word_store[read_word];
					read_word = (read_word + 1) % RING;
					moves_to_read--;
					r.last = (moves_to_read == 0 && ticks_to_read == 0);
				end else if (ticks_to_read != 0) begin
					r.kind        = KIND_TICK;
					r.tick        = slot_header[read_slot];
					r.count       = 5'(slot_count[read_slot]);
					read_word     = slot_base[read_slot];
					moves_to_read = slot_count[read_slot];
					read_slot     = (read_slot + 1) % TICKS;
					ticks_to_read--;
					r.last = (moves_to_read == 0 && ticks_to_read == 0);
				end else begin
					r.status = STAT_NO_READ;
					r.last   = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	function automatic cmd_beat_t random_beat(cmd_t c);
		cmd_beat_t b;
		b.cmd        = c;
		b.tick_word  = {$urandom, $urandom};
		b.move_count = 5'($urandom_range(0, 31));
		b.move_word  = {$urandom, $urandom};
		b.wish       = 16'($urandom_range(0, 65535));
		return b;
	endfunction

	// Send one command beat, optionally after an idle gap, and log its result
	task automatic send_beat(cmd_beat_t b);
		record_t expected_rec;
		if (gap_pct != 0 && $urandom_range(99) < gap_pct)
			repeat ($urandom_range(1, 6)) @(negedge clk);
		@(negedge clk);
		start      <= 1'b1;
		command    <= b.cmd;
		tick_word  <= b.tick_word;
		move_count <= b.move_count;
		move_word  <= b.move_word;
		wish_ticks <= b.wish;
		do @(posedge clk); while (busy !== 1'b0);
		expected_rec = predict_record(b);
		awaited_records.insert(awaited_records.size(), expected_rec);
		beats_sent++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic do_begin(int n, logic [63:0] word);
		cmd_beat_t b;
		b            = random_beat(CMD_BEGIN);
		b.move_count = 5'(n);
		b.tick_word  = word;
		send_beat(b);
	endtask

	task automatic do_append(logic [63:0] word);
		cmd_beat_t b;
		b           = random_beat(CMD_APPEND);
		b.move_word = word;
		send_beat(b);
	endtask

	task automatic do_readout(int wish);
		cmd_beat_t b;
		b      = random_beat(CMD_READOUT);
		b.wish = 16'(wish);
		send_beat(b);
	endtask

	// Step the readout; never let it fetch a payload word not yet written
	task automatic do_next();
		cmd_beat_t b;
		b = random_beat(CMD_NEXT);
		if (moves_to_read != 0 && !word_written[read_word]) begin
			if (pending_moves != 0) begin
				b.cmd = CMD_APPEND;
			end else begin
				b.cmd  = CMD_READOUT;
				b.wish = 16'($urandom_range(0, 8));
			end
		end
		send_beat(b);
	endtask

	task automatic read_all(int cap);
		int i;
		i = 0;
		while ((ticks_to_read != 0 || moves_to_read != 0) && i < cap) begin
			do_next();
			i++;
		end
	endtask

	// Hold off until every awaited record has come back
	task automatic drain();
		while (awaited_records.size() != 0) @(posedge clk);
	endtask

	task automatic test_after_reset();
		do_next();
		do_readout(0);
		do_readout(3);
		read_all(10);
		do_next();
	endtask

	task automatic test_field_extremes();
		do_begin(31, '1);
		do_append('0);
		do_append('1);
		do_append(64'h5555_5555_5555_5555);
		do_append(64'haaaa_aaaa_aaaa_aaaa);
		do_readout(1);
		read_all(40);
		do_append({$urandom, $urandom});
		do_readout(16'hffff);
		do_readout(TICKS);
		do_readout(TICKS + 1);
		do_next();
	endtask

	task automatic test_incomplete_tick();
		do_begin(3, {$urandom, $urandom});
		do_append({$urandom, $urandom});
		do_begin(0, {$urandom, $urandom});
		do_readout(2);
		read_all(10);
		// begin a new tick and append its moves while a readout runs
		do_readout(4);
		do_next();
		do_begin(2, {$urandom, $urandom});
		do_append({$urandom, $urandom});
		do_append({$urandom, $urandom});
		read_all(20);
	endtask

	task automatic test_ring_wrap();
		repeat (TICKS + 6) do_begin(0, {$urandom, $urandom});
		do_readout(6);
		read_all(10);
		do_readout(16'hffff);
		repeat (3) do_next();
	endtask

	// One short piece of traffic: mostly well-formed ticks and readouts
	task automatic random_episode();
		int pick, n, k, extra;
		pick = $urandom_range(99);
		if (pick < 55) begin
			case ($urandom_range(9))
				0:       n = $urandom_range(MOVES_MAX + 1, 31);
				1, 2:    n = $urandom_range(6, MOVES_MAX);
				default: n = $urandom_range(0, 5);
			endcase
			do_begin(n, {$urandom, $urandom});
			k = (n > MOVES_MAX) ? MOVES_MAX : n;
			extra = 0;
			case ($urandom_range(9))
				0: k = (k == 0) ? 0 : $urandom_range(0, k - 1);
				1: extra = $urandom_range(1, 2);
				default: ;
			endcase
			repeat (k + extra) do_append({$urandom, $urandom});
		end else if (pick < 85) begin
			case ($urandom_range(9))
				0, 1: begin
					do_readout($urandom_range(0, 65535));
					repeat ($urandom_range(0, 5)) do_next();
				end
				2: begin
					do_readout($urandom_range(0, 12));
					repeat ($urandom_range(0, 5)) do_next();
				end
				default: begin
					do_readout($urandom_range(0, 12));
					read_all(250);
					if ($urandom_range(3) == 0) do_next();
				end
			endcase
		end else begin
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(3))
					0: send_beat(random_beat(CMD_BEGIN));
					1: send_beat(random_beat(CMD_APPEND));
					2: send_beat(random_beat(CMD_READOUT));
					default: do_next();
				endcase
			end
		end
	endtask

	task automatic test_random_traffic(int pct, int beats);
		int target;
		gap_pct = pct;
		target  = beats_sent + beats;
		while (beats_sent < target) random_episode();
		drain();
	endtask

	// Check each result beat against the oldest awaited record
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (awaited_records.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORTS)
					$display("record with none awaited: kind %0d status %0d", kind, status);
			end else begin
				head_record = awaited_records[0];
				awaited_records.delete(0);
				if (kind !== head_record.kind || out_tick !== head_record.tick ||
				    out_count !== head_record.count || out_move !== head_record.move ||
				    ticks_found !== head_record.found || last !== head_record.last ||
				    status !== head_record.status) begin
					mismatches++;
					if (mismatches <= REPORTS) begin
						$display("exp kind %0d tick %h count %0d move %h found %0d last %0d st %0d",
							head_record.kind, head_record.tick, head_record.count,
							head_record.move, head_record.found, head_record.last,
							head_record.status);
						$display("got kind %0d tick %h count %0d move %h found %0d last %0d st %0d",
							kind, out_tick, out_count, out_move, ticks_found, last, status);
					end
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		command     = CMD_BEGIN;
		tick_word   = '0;
		move_count  = '0;
		move_word   = '0;
		wish_ticks  = '0;
		beats_sent  = 0;
		gap_pct     = 0;
		for (int i = 0; i < TICKS; i++) begin
			slot_header[i] = '0;
			slot_count[i]  = 0;
			slot_base[i]   = 0;
		end
		for (int i = 0; i < RING; i++) begin
			word_store[i]   = '0;
			word_written[i] = 1'b0;
		end
		next_slot     = 0;
		next_word     = 0;
		pending_moves = 0;
		read_slot     = 0;
		read_word     = 0;
		ticks_to_read = 0;
		moves_to_read = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		gap_pct = 25;
		test_after_reset();
		test_field_extremes();
		test_incomplete_tick();
		drain();
		test_ring_wrap();
		drain();
		test_random_traffic(25, 40);
		test_random_traffic(78, 40);
		test_random_traffic(0, 40);

		drain();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/trvp_pkg.sv
hw/rtl/trvp_ram.sv
hw/rtl/trvp_ctrl.sv
hw/rtl/trvp_dp.sv
hw/rtl/trace_ring_with_variable_payload.sv
sim/testbench.sv
